// File: src/vpbc_pkg.sv
package vpbc_pkg;

  localparam int FIX_FRAC = 16;
  localparam int NUM_W    = 66;   // numerator magnitude width, headroom kept
  localparam int DEN_W    = 33;   // |w| magnitude width

  typedef enum logic [1:0] {
    REG_X_SCALE      = 2'd0,
    REG_Y_SCALE      = 2'd1,
    REG_DEPTH_SCALE  = 2'd2,
    REG_DEPTH_OFFSET = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic signed [31:0] vertex_x;
    logic signed [31:0] vertex_y;
    logic signed [31:0] vertex_z;
    logic               last_in_face;
  } in_beat_t;

  typedef struct packed {
    logic signed [31:0] ndc_x;
    logic signed [31:0] ndc_y;
    logic signed [31:0] ndc_z;
    logic               outside_frustum;
    logic               w_was_zero;
    logic               face_end;
    logic               face_cull;
  } out_beat_t;

  // Work handed from the front end to the divide/cull back end.
  typedef struct packed {
    logic signed [64:0] num_x;
    logic signed [64:0] num_y;
    logic signed [64:0] num_z;
    logic signed [32:0] den;
    logic               wzero;
    logic               last;
  } job_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_DIV  = 2'd1,
    ST_AREA = 2'd2,
    ST_DONE = 2'd3
  } be_state_t;

endpackage

// File: src/vpbc_front.sv
module vpbc_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  vpbc_pkg::in_beat_t   in_data,
  input  logic signed [31:0]   x_scale,
  input  logic signed [31:0]   y_scale,
  input  logic signed [31:0]   depth_scale,
  input  logic signed [31:0]   depth_offset,
  output logic                 job_valid,
  input  logic                 job_ready,
  output vpbc_pkg::job_t       job
);
  import vpbc_pkg::*;

  // Stage 1: products registered; stage 2: depth offset add, job formed.
  logic               s1_v_r;
  logic signed [63:0] px_r, py_r, pz_r;
  logic signed [31:0] z_r;
  logic               last_r;
  logic               s2_v_r;
  job_t               job_r;
  logic               adv2, adv1;
  logic signed [64:0] nz;
  logic signed [32:0] w;

  assign adv2     = !s2_v_r || job_ready;
  assign adv1     = !s1_v_r || adv2;
  assign in_ready = adv1;

  assign nz = 65'(pz_r) + {{17{depth_offset[31]}}, depth_offset, 16'd0};
  assign w  = -33'(z_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      if (adv1) s1_v_r <= in_valid;
      if (adv2) s2_v_r <= s1_v_r;
    end
    if (adv1 && in_valid) begin
      px_r   <= in_data.vertex_x * x_scale;
      py_r   <= in_data.vertex_y * y_scale;
      pz_r   <= in_data.vertex_z * depth_scale;
      z_r    <= in_data.vertex_z;
      last_r <= in_data.last_in_face;
    end
    if (adv2 && s1_v_r) begin
      job_r.num_x <= 65'(px_r);
      job_r.num_y <= 65'(py_r);
      job_r.num_z <= nz;
      job_r.wzero <= (z_r == 32'sd0);
      job_r.den   <= (z_r == 32'sd0) ? 33'sd65536 : w;
      job_r.last  <= last_r;
    end
  end

  assign job_valid = s2_v_r;
  assign job       = job_r;
endmodule

// File: src/vpbc_fifo.sv
module vpbc_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr_valid,
  output logic            wr_ready,
  input  vpbc_pkg::job_t  wr_data,
  output logic            rd_valid,
  input  logic            rd_ready,
  output vpbc_pkg::job_t  rd_data
);
  import vpbc_pkg::*;

  // Two-entry queue.
  job_t       mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       wr, rd;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_data  = mem_r[rp_r];
  assign wr = wr_valid && wr_ready;
  assign rd = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr) wp_r <= ~wp_r;
      if (rd) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(wr) - 2'(rd);
    end
    if (wr) mem_r[wp_r] <= wr_data;
  end
endmodule

// File: src/vpbc_back.sv
module vpbc_back #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                job_valid,
  output logic                job_ready,
  input  vpbc_pkg::job_t      job,
  output logic                out_valid,
  input  logic                out_ready,
  output vpbc_pkg::out_beat_t out_data
);
  import vpbc_pkg::*;

  localparam int SAT_BITS = (COORD_WIDTH > 32) ? 32 : COORD_WIDTH;
  localparam logic [63:0] LIM = 64'd1 << (SAT_BITS - 1);
  localparam int CW = $clog2(NUM_W + 1);

  be_state_t state_r, state_nxt;
  logic [1:0] lane_r;          // 0,1,2 = x,y,z quotient in turn
  logic [CW-1:0] bit_r;
  logic [NUM_W-1:0] q_r;
  logic [DEN_W:0]   rem_r;
  logic [DEN_W-1:0] dmag_r;
  job_t jb_r;
  logic signed [31:0] qx_r, qy_r, qz_r;

  // Face state.
  logic signed [31:0] first_px_r, first_py_r, prev_px_r, prev_py_r;
  logic signed [63:0] area_sum_r;
  logic               at_face_start_r;
  logic [1:0]         astep_r;
  logic signed [63:0] prod_a_r, prod_b_r;
  logic signed [63:0] term_r;

  out_beat_t ob_r;
  logic      ov_r;

  logic signed [64:0] cur_num;
  logic [NUM_W-1:0]   nmag;
  logic [DEN_W:0]     rem_sh, rem_sub;
  logic               neg;
  logic signed [31:0] qsat;

  function automatic logic signed [63:0] add_sat(logic signed [63:0] a,
                                                 logic signed [63:0] b);
    logic signed [64:0] s;
    s = 65'(a) + 65'(b);
    if (s[64] != s[63]) return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    return s[63:0];
  endfunction

  always_comb begin
    case (lane_r)
      2'd0:    cur_num = jb_r.num_x;
      2'd1:    cur_num = jb_r.num_y;
      default: cur_num = jb_r.num_z;
    endcase
  end
  assign nmag = cur_num[64] ? NUM_W'(-cur_num) : NUM_W'(cur_num);
  assign neg  = cur_num[64] ^ jb_r.den[32];

  // Restoring divide, one quotient bit per cycle.
  assign rem_sh  = {rem_r[DEN_W-1:0], nmag[bit_r[CW-1:0] - CW'(1)]};
  assign rem_sub = rem_sh - {1'b0, dmag_r};

  always_comb begin
    logic [NUM_W-1:0] q;
    q = q_r;
    if (neg) begin
      if (64'(q) >= LIM || q[NUM_W-1:64] != '0) qsat = 32'(-$signed({1'b0, LIM}));
      else qsat = 32'(-$signed({1'b0, q[63:0]}));
    end else begin
      if (64'(q) > LIM - 64'd1 || q[NUM_W-1:64] != '0) qsat = 32'(LIM - 64'd1);
      else qsat = 32'(q);
    end
  end

  assign job_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (job_valid) state_nxt = ST_DIV;
      ST_DIV:  if (bit_r == CW'(0) && lane_r == 2'd2) state_nxt = ST_AREA;
      ST_AREA: if (astep_r == 2'd3) state_nxt = ST_DONE;
      ST_DONE: if (!ov_r || out_ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= ST_IDLE;
      ov_r            <= 1'b0;
      at_face_start_r <= 1'b1;
      area_sum_r      <= '0;
      first_px_r      <= '0;
      first_py_r      <= '0;
      prev_px_r       <= '0;
      prev_py_r       <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_DONE && (!ov_r || out_ready)) ov_r <= 1'b1;
      else if (out_ready) ov_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: if (job_valid) begin
          jb_r   <= job;
          lane_r <= 2'd0;
          bit_r  <= CW'(NUM_W);
          rem_r  <= '0;
          q_r    <= '0;
          dmag_r <= job.den[32] ? DEN_W'(-job.den) : DEN_W'(job.den);
          astep_r <= 2'd0;
        end
        ST_DIV: begin
          if (bit_r != CW'(0)) begin
            if (!rem_sub[DEN_W]) begin
              rem_r <= rem_sub;
              q_r   <= {q_r[NUM_W-2:0], 1'b1};
            end else begin
              rem_r <= rem_sh;
              q_r   <= {q_r[NUM_W-2:0], 1'b0};
            end
            bit_r <= bit_r - CW'(1);
          end else begin
            case (lane_r)
              2'd0:    qx_r <= qsat;
              2'd1:    qy_r <= qsat;
              default: qz_r <= qsat;
            endcase
            lane_r <= lane_r + 2'd1;
            bit_r  <= CW'(NUM_W);
            rem_r  <= '0;
            q_r    <= '0;
          end
        end
        ST_AREA: begin
          astep_r <= astep_r + 2'd1;
          case (astep_r)
            2'd0: begin
              prod_a_r <= prev_px_r * qy_r;
              prod_b_r <= prev_py_r * qx_r;
            end
            2'd1: begin
              term_r <= add_sat(prod_a_r, -prod_b_r);
              // a face opening here closes onto this same vertex
              prod_a_r <= qx_r * (at_face_start_r ? qy_r : first_py_r);
              prod_b_r <= qy_r * (at_face_start_r ? qx_r : first_px_r);
            end
            2'd2: begin
              if (at_face_start_r) begin
                area_sum_r <= '0;
                first_px_r <= qx_r;
                first_py_r <= qy_r;
              end else begin
                area_sum_r <= add_sat(area_sum_r, term_r);
              end
              term_r <= add_sat(prod_a_r, -prod_b_r);
            end
            default: ;
          endcase
        end
        ST_DONE: if (!ov_r || out_ready) begin
          logic signed [63:0] fin;
          fin = add_sat(area_sum_r, term_r);
          ob_r.ndc_x <= qx_r;
          ob_r.ndc_y <= qy_r;
          ob_r.ndc_z <= qz_r;
          ob_r.outside_frustum <= (qx_r < -32'sd65536) || (qx_r > 32'sd65536) ||
                                  (qy_r < -32'sd65536) || (qy_r > 32'sd65536) ||
                                  (qz_r < 32'sd0) || (qz_r > 32'sd65536);
          ob_r.w_was_zero <= jb_r.wzero;
          ob_r.face_end   <= jb_r.last;
          ob_r.face_cull  <= jb_r.last && fin[63];
          prev_px_r <= qx_r;
          prev_py_r <= qy_r;
          if (jb_r.last) begin
            area_sum_r      <= '0;
            at_face_start_r <= 1'b1;
          end else begin
            at_face_start_r <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_valid = ov_r;
  assign out_data  = ob_r;
endmodule

// File: src/vertex_projection_backface_cull.sv
// Path: the input beat passes the front stages, is written to the queue and
//   accepted by the back end; three serial divides (x, y, z), the area steps
//   and the output register then lead to result valid.
// Flow: the back end holds one vertex at a time and takes the next only when idle.
// Reset: synchronous active-low rst_n; registers return to their reset
//   values, the queue empties and the face accumulator restarts.
module vertex_projection_backface_cull #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  vpbc_pkg::in_beat_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output vpbc_pkg::out_beat_t out_data,
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [3:0]          cfg_paddr,
  input  logic [31:0]         cfg_pwdata,
  output logic [31:0]         cfg_prdata,
  output logic                cfg_pready
);
  import vpbc_pkg::*;

  logic signed [31:0] x_scale_r, y_scale_r, depth_scale_r, depth_offset_r;
  reg_idx_t idx;
  logic     wr_en;

  assign cfg_pready = 1'b1;
  assign idx   = reg_idx_t'(cfg_paddr[3:2]);
  assign wr_en = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_scale_r      <= 32'sd65536;
      y_scale_r      <= 32'sd65536;
      depth_scale_r  <= -32'sd65536;
      depth_offset_r <= -32'sd131072;
    end else if (wr_en) begin
      unique case (idx)
        REG_X_SCALE:      x_scale_r      <= cfg_pwdata;
        REG_Y_SCALE:      y_scale_r      <= cfg_pwdata;
        REG_DEPTH_SCALE:  depth_scale_r  <= cfg_pwdata;
        REG_DEPTH_OFFSET: depth_offset_r <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_X_SCALE:      cfg_prdata = x_scale_r;
      REG_Y_SCALE:      cfg_prdata = y_scale_r;
      REG_DEPTH_SCALE:  cfg_prdata = depth_scale_r;
      REG_DEPTH_OFFSET: cfg_prdata = depth_offset_r;
      default:          cfg_prdata = '0;
    endcase
  end

  // Front: products; queue; back: divide and face area.
  logic fj_valid, fj_ready, bj_valid, bj_ready;
  job_t fj, bj;

  vpbc_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_data,
    .x_scale(x_scale_r), .y_scale(y_scale_r),
    .depth_scale(depth_scale_r), .depth_offset(depth_offset_r),
    .job_valid(fj_valid), .job_ready(fj_ready), .job(fj)
  );

  vpbc_fifo u_fifo (
    .clk, .rst_n, .wr_valid(fj_valid), .wr_ready(fj_ready), .wr_data(fj),
    .rd_valid(bj_valid), .rd_ready(bj_ready), .rd_data(bj)
  );

  vpbc_back #(.COORD_WIDTH(COORD_WIDTH)) u_back (
    .clk, .rst_n, .job_valid(bj_valid), .job_ready(bj_ready), .job(bj),
    .out_valid, .out_ready, .out_data
  );

  // Cull is only ever reported on a face's closing beat.
  a_cull_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!out_data.face_cull || out_data.face_end))
    else $error("cull without face end");

  // A pending result beat stays valid until it is taken.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped");
endmodule
